FILE: src/mbps_pkg.sv
// Shared constants, types and helpers for the masked byte pattern search.
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  // Pattern registers hold at most sixteen bytes.
  localparam int PATTERN_CAP = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
  localparam int IDX_W       = (PATTERN_CAP > 1) ? $clog2(PATTERN_CAP) : 1;
  localparam int LEN_W       = 5;
  localparam int COUNT_W     = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_CARE_MASK      = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } chain_ctrl_t;

  typedef logic [PATTERN_CAP-1:0][7:0] pattern_bytes_t;

  // Clamp the programmed length into 1..PATTERN_CAP and return length - 1.
  function automatic logic [IDX_W-1:0] len_index(input logic [LEN_W-1:0] len);
    logic [IDX_W-1:0] idx;
    if (len == '0) begin
      idx = '0;
    end else if (int'(len) > PATTERN_CAP) begin
      idx = IDX_W'(PATTERN_CAP - 1);
    end else begin
      idx = IDX_W'(len - LEN_W'(1));
    end
    return idx;
  endfunction

endpackage

FILE: src/mbps_byte_if.sv
// Input channel: one region byte per beat.
interface mbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

FILE: src/mbps_result_if.sv
// Result channel: found flag and start offset of the match.
interface mbps_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

FILE: src/mbps_cfg_if.sv
// Configuration write channel: register index and write data.
interface mbps_cfg_if
  import mbps_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: src/mbps_cell.sv
// One cell of the match chain: tracks whether pattern bytes 0..i matched so far.
module mbps_cell
  import mbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  input  logic        prev_match,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  pat_byte,
  input  logic        care,
  output logic        hit,
  output logic        match
);

  // Prefix through this cell matches ending at the current byte.
  assign hit = prev_match & (~care | (data_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.advance) begin
      match <= hit;
    end
  end

endmodule

FILE: src/mbps_chain.sv
// Row of match cells; each cell hands its prefix match to the next one.
module mbps_chain
  import mbps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  chain_ctrl_t            ctrl,
  input  logic [7:0]             data_byte,
  input  pattern_bytes_t         pat_bytes,
  input  logic [PATTERN_CAP-1:0] care,
  output logic [PATTERN_CAP-1:0] hit
);

  logic [PATTERN_CAP-1:0] match;
  logic [PATTERN_CAP-1:0] prev_match;

  // The first cell always starts a fresh prefix.
  assign prev_match = {match[PATTERN_CAP-2:0], 1'b1};

  for (genvar i = 0; i < PATTERN_CAP; i++) begin : g_cell
    mbps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_match (prev_match[i]),
      .data_byte  (data_byte),
      .pat_byte   (pat_bytes[i]),
      .care       (care[i]),
      .hit        (hit[i]),
      .match      (match[i])
    );
  end

endmodule

FILE: src/masked_byte_pattern_search.sv
// Masked byte pattern search: finds the first place in a byte region where a
// pattern of up to 16 bytes matches, with cleared care bits acting as wildcards.
// One byte is taken per beat and a new byte may follow every cycle; a row of
// compare cells carries the partial matches along, so the result for a byte is
// decided in the cycle it is accepted and appears on the result channel in the
// next cycle from an output register. Input ready drops only while that
// register holds a result the sink has not taken. One result per region: the
// start offset on the first match, or found 0 with offset 0 on the last byte.
// Configuration writes are always accepted and must be issued while idle.
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input logic          clk,
  input logic          rst,
  mbps_cfg_if.sink     cfg,
  mbps_byte_if.sink    byte_in,
  mbps_result_if.source result_out
);

  logic [63:0]          pattern_low;
  logic [63:0]          pattern_high;
  logic [15:0]          care_mask;
  logic [LEN_W-1:0]     pattern_length;

  logic [COUNT_W-1:0]   bytes_seen;
  logic [COUNT_W-1:0]   bytes_seen_next;
  logic                 match_done;

  logic                 out_valid;
  logic                 out_found;
  logic [COUNT_W-1:0]   out_offset;

  logic                 accept;
  logic                 load;
  logic                 match_hit;
  logic [IDX_W-1:0]     len_idx;
  logic [COUNT_W-1:0]   offset;
  logic [PATTERN_CAP-1:0] hit;
  pattern_bytes_t       pat_bytes;
  chain_ctrl_t          ctrl;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_PATTERN_LOW:    pattern_low    <= cfg.wdata;
        REG_PATTERN_HIGH:   pattern_high   <= cfg.wdata;
        REG_CARE_MASK:      care_mask      <= cfg.wdata[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg.wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_CAP; i++) begin
      if (i < 8) begin
        pat_bytes[i] = pattern_low[8*i +: 8];
      end else begin
        pat_bytes[i] = pattern_high[8*(i-8) +: 8];
      end
    end
  end

  // Match chain
  assign byte_in.ready = ~out_valid | result_out.ready;
  assign accept        = byte_in.valid & byte_in.ready;
  assign ctrl.advance  = accept & ~match_done;
  assign ctrl.clear    = accept & byte_in.last_byte;

  mbps_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .data_byte (byte_in.data_byte),
    .pat_bytes (pat_bytes),
    .care      (care_mask[PATTERN_CAP-1:0]),
    .hit       (hit)
  );

  assign len_idx   = len_index(pattern_length);
  assign match_hit = hit[len_idx];

  // Saturate the byte count at its maximum.
  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + COUNT_W'(1);
  assign offset = bytes_seen_next - (COUNT_W'(len_idx) + COUNT_W'(1));

  assign load = ctrl.advance & (match_hit | byte_in.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else if (ctrl.clear) begin
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else if (ctrl.advance) begin
      bytes_seen <= bytes_seen_next;
      if (match_hit) begin
        match_done <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found  <= match_hit;
      out_offset <= match_hit ? offset : '0;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.found        = out_found;
  assign result_out.match_offset = out_offset;

`ifndef SYNTHESIS
  a_match_sets_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance && match_hit && !byte_in.last_byte |=> match_done)
    else $error("match did not mark the region done");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.last_byte |=> (bytes_seen == '0) && !match_done)
    else $error("last byte did not clear the region state");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_out.ready |-> !byte_in.ready)
    else $error("byte accepted while a result was stalled");

  a_not_found_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_offset == '0)
    else $error("not-found result carries a nonzero offset");
`endif

endmodule

FILE: tb/masked_byte_pattern_search_checker.sv
// Checker for the masked byte pattern search: predicts each region's result and compares.
module masked_byte_pattern_search_checker
  import mbps_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  mbps_cfg_if    cfg,
  mbps_byte_if   byte_in,
  mbps_result_if result_out,
  output int     errors,
  output int     outstanding,
  output int     results_seen
);

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } search_result_t;

  logic [63:0]        pat_low;
  logic [63:0]        pat_high;
  logic [15:0]        care_bits;
  logic [LEN_W-1:0]   pat_len;
  logic [7:0]         window_bytes [PATTERN_CAP];
  logic [COUNT_W-1:0] byte_count;
  logic               region_matched;
  search_result_t     expected_results [$];
  int                 mismatch_count = 0;
  int                 result_count = 0;

  assign errors = mismatch_count;
  assign results_seen = result_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] search check: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int active_length();
    if (pat_len == '0) return 1;
    if (int'(pat_len) > PATTERN_CAP) return PATTERN_CAP;
    return int'(pat_len);
  endfunction

  function automatic logic [7:0] wanted_byte(input int i);
    if (i < 8) return pat_low[8*i +: 8];
    return pat_high[8*(i-8) +: 8];
  endfunction

  // Pattern byte i lines up with the byte taken len-1-i beats ago.
  function automatic bit window_hits(input int len);
    for (int i = 0; i < len; i++) begin
      if (care_bits[i] && window_bytes[len-1-i] != wanted_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int len;
    // Drop bytes after a match; the last byte only closes the region.
    if (region_matched) begin
      if (last) begin
        byte_count = '0;
        region_matched = 1'b0;
      end
      return;
    end
    for (int i = PATTERN_CAP - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = b;
    if (byte_count != '1) byte_count++;
    len = active_length();
    if (byte_count >= COUNT_W'(len) && window_hits(len)) begin
      expected_results.push_back('{found: 1'b1, offset: byte_count - COUNT_W'(len)});
      if (last) begin
        byte_count = '0;
      end else begin
        region_matched = 1'b1;
      end
    end else if (last) begin
      expected_results.push_back('{found: 1'b0, offset: '0});
      byte_count = '0;
    end
  endtask

  task automatic check_result(input logic found, input logic [31:0] offset);
    search_result_t want;
    result_count++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result found=%0b offset=%0d", found, offset));
      return;
    end
    want = expected_results.pop_front();
    if (found !== want.found) begin
      report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
    end
    if (offset !== want.offset) begin
      report_mismatch($sformatf("match_offset %0d, expected %0d", offset, want.offset));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_low = '0;
      pat_high = '0;
      care_bits = '0;
      pat_len = LEN_W'(1);
      byte_count = '0;
      region_matched = 1'b0;
      foreach (window_bytes[i]) window_bytes[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_PATTERN_LOW:    pat_low = cfg.wdata;
          REG_PATTERN_HIGH:   pat_high = cfg.wdata;
          REG_CARE_MASK:      care_bits = cfg.wdata[15:0];
          REG_PATTERN_LENGTH: pat_len = cfg.wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      // A result taken on this edge belongs to an earlier byte: check before predicting.
      if (result_out.valid && result_out.ready) begin
        check_result(result_out.found, result_out.match_offset);
      end
      if (byte_in.valid && byte_in.ready) begin
        take_byte(byte_in.data_byte, byte_in.last_byte);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: tb/masked_byte_pattern_search_tb.sv
// Testbench top for the masked byte pattern search: settings, byte regions and verdict.
module masked_byte_pattern_search_tb
  import mbps_pkg::*;
;

  localparam int PHASES        = 13;
  localparam int PHASE_BYTES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 600000;

  typedef logic [7:0] byte_queue_t [$];

  logic        clk = 1'b0;
  logic        rst;
  int          cycle_count = 0;
  int          errors;
  int          outstanding;
  int          results_seen;
  int          bytes_sent = 0;
  int          regions_sent = 0;
  int          settings_used = 0;
  bit          sender_calm = 1'b0;
  bit          sink_calm = 1'b0;
  logic [63:0] cur_low;
  logic [63:0] cur_high;
  logic [15:0] cur_care;
  logic [4:0]  cur_len;

  mbps_cfg_if    cfg_ch ();
  mbps_byte_if   byte_ch ();
  mbps_result_if result_ch ();

  masked_byte_pattern_search dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .byte_in    (byte_ch),
    .result_out (result_ch)
  );

  masked_byte_pattern_search_checker search_check (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_ch),
    .byte_in      (byte_ch),
    .result_out   (result_ch),
    .errors       (errors),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("masked_byte_pattern_search: mismatch");
      $finish;
    end
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] pattern_at(input int i);
    if (i < 8) return cur_low[8*i +: 8];
    return cur_high[8*(i-8) +: 8];
  endfunction

  // Half the filler comes from the pattern itself so near misses are common.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return pattern_at($urandom_range(0, PATTERN_CAP - 1));
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_region(input byte_queue_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    regions_sent++;
    if ($urandom_range(0, 7) == 0) sender_calm = !sender_calm;
  endtask

  // Hold valid across writes; the caller drops it after the last one.
  task automatic write_reg(input cfg_reg_t r, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.wdata <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_search(input logic [63:0] low, input logic [63:0] high,
                                input logic [15:0] care, input logic [4:0] len);
    cur_low  = low;
    cur_high = high;
    cur_care = care;
    cur_len  = len;
    write_reg(REG_PATTERN_LOW, low);
    write_reg(REG_PATTERN_HIGH, high);
    write_reg(REG_CARE_MASK, 64'(care));
    write_reg(REG_PATTERN_LENGTH, 64'(len));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly planted patterns with random wildcard bytes; some corrupted, cut short, or noise.
  task automatic random_region();
    byte_queue_t q;
    int          len;
    int          kind;
    int          start;
    int          cut;
    if (cur_len == '0) begin
      len = 1;
    end else if (int'(cur_len) > PATTERN_CAP) begin
      len = PATTERN_CAP;
    end else begin
      len = int'(cur_len);
    end
    kind = $urandom_range(0, 99);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5)) begin
      q.push_back(noise_byte());
    end
    if (kind < 90) begin
      start = q.size();
      for (int i = 0; i < len; i++) q.push_back(cur_care[i] ? pattern_at(i) : 8'($urandom));
      if (kind >= 65 && kind < 80) begin
        cut = start + $urandom_range(0, len - 1);
        q[cut] = q[cut] ^ 8'($urandom_range(1, 255));
      end
      // End the region before the last pattern byte, possibly before its first.
      if (kind >= 80) begin
        cut = $urandom_range(0, len - 1);
        repeat (len - cut) void'(q.pop_back());
      end
    end
    if (kind < 80 || kind >= 90) begin
      repeat ($urandom_range(0, 6)) q.push_back(noise_byte());
    end
    if (q.size() == 0) q.push_back(noise_byte());
    send_region(q);
  endtask

  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(sink_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
    end
  end

  initial begin
    byte_queue_t q;
    int          phase_end;
    rst               <= 1'b1;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_PATTERN_LOW;
    cfg_ch.wdata      <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    cur_low  = '0;
    cur_high = '0;
    cur_care = '0;
    cur_len  = 5'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one wildcard byte, so the first byte matches and the rest is dropped.
    q = {8'h00, 8'hFF};
    send_region(q);
    wait_idle();

    // Byte 2 is a wildcard; the match completes on the region's last byte.
    program_search(64'h0000_0000_DDCC_BBAA, '0, 16'h000B, 5'd4);
    q = {8'h11, 8'hAA, 8'hBB, 8'h5A, 8'hDD};
    send_region(q);
    q = {8'hAA, 8'hBB};
    send_region(q);
    q = {8'h00, 8'hFF, 8'h00};
    send_region(q);
    wait_idle();

    // Zero length acts as one byte.
    program_search(64'hFFFF_FFFF_FFFF_FF00, '1, 16'h0001, 5'd0);
    q = {8'hFF, 8'h00, 8'hFF};
    send_region(q);
    wait_idle();

    // Length above sixteen acts as sixteen, so three bytes fall short.
    program_search('0, '0, 16'h0000, 5'd17);
    q = {8'h01, 8'h02, 8'h03};
    send_region(q);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16);
        1: program_search('1, '1, 16'hFFFF, 5'd16);
        2: program_search('0, '0, 16'($urandom), 5'd31);
        3: program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd16);
        4: program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd0);
        5: program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd1);
        6: program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd17);
        default: begin
          program_search({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                         5'($urandom_range(1, 16)));
        end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_region();
    end
    wait_idle();

    $display("Scanned %0d regions (%0d bytes) under %0d pattern settings,",
             regions_sent, bytes_sent, settings_used);
    $display("with %0d results compared and %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("masked_byte_pattern_search: match");
    end else begin
      $display("masked_byte_pattern_search: mismatch");
    end
    $finish;
  end

endmodule

FILE: masked_byte_pattern_search.f
src/mbps_pkg.sv
src/mbps_byte_if.sv
src/mbps_result_if.sv
src/mbps_cfg_if.sv
src/mbps_cell.sv
src/mbps_chain.sv
src/masked_byte_pattern_search.sv
tb/masked_byte_pattern_search_checker.sv
tb/masked_byte_pattern_search_tb.sv
